// ===== sv/rmts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmts_pkg;

  // Widths fixed by the register map and the result word.
  localparam int NUM_SETTINGS = 4;
  localparam int SET_W        = 32;
  localparam int CNT_W        = 16;
  localparam int TIME_W       = 32;
  localparam int CFG_ADDR_W   = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 40;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } rmts_state_t;

  // One scheduler result.
  typedef struct packed {
    logic              busy;
    logic [1:0]        idx;
    logic              done;
    logic [TIME_W-1:0] tick;
  } rmts_res_t;

endpackage

`default_nettype wire

// ===== sv/rmts_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmts_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rmts_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [rmts_pkg::SET_W-1:0]       cfg_wdata,
  input  wire logic [rmts_pkg::CFG_ADDR_W-1:0]  rd_idx,
  output logic      [rmts_pkg::SET_W-1:0]       rd_setting
);
  import rmts_pkg::*;

  logic [SET_W-1:0] setting_r [NUM_SETTINGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SETTINGS; i++) begin
        setting_r[i] <= '0;
      end
    end else if (cfg_we) begin
      setting_r[cfg_addr] <= cfg_wdata;
    end
  end

  assign rd_setting = setting_r[rd_idx];

endmodule

`default_nettype wire

// ===== sv/rmts_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmts_core #(
  parameter int NUM_TASKS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             restart,
  output logic                                  idle,
  output logic      [rmts_pkg::CFG_ADDR_W-1:0]  rd_idx,
  input  wire logic [rmts_pkg::SET_W-1:0]       rd_setting,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output rmts_pkg::rmts_res_t                   res
);
  import rmts_pkg::*;

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  rmts_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic              restart_r, restart_nxt;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  best_per_r, best_per_nxt;
  logic [CNT_W-1:0]  best_rem_r, best_rem_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;
  logic [CNT_W-1:0]  phase_r [NUM_TASKS];
  logic [CNT_W-1:0]  phase_nxt [NUM_TASKS];
  logic [CNT_W-1:0]  rem_r [NUM_TASKS];
  logic [CNT_W-1:0]  rem_nxt [NUM_TASKS];

  // Shared per-task datapath, applied to the task under the scan index.
  logic [7:0]       idx_ext;
  logic [7:0]       pick_ext;
  logic             has_reg;
  logic [CNT_W-1:0] period;
  logic [CNT_W-1:0] burst;
  logic             task_en;
  logic [CNT_W-1:0] ph;
  logic [CNT_W:0]   ph_inc;
  logic [CNT_W-1:0] ph_adv;
  logic [CNT_W-1:0] rem_rel;
  logic             better;

  assign idx_ext  = 8'(scan_idx_r);
  assign pick_ext = 8'(pick_r);
  assign has_reg  = idx_ext < 8'(NUM_SETTINGS);
  assign rd_idx   = idx_ext[CFG_ADDR_W-1:0];
  assign period   = rd_setting[SET_W-1:CNT_W];
  assign burst    = rd_setting[CNT_W-1:0];
  assign task_en  = has_reg && (period != '0) && (burst != '0);
  assign ph       = restart_r ? '0 : phase_r[scan_idx_r];
  assign ph_inc   = {1'b0, ph} + 1'b1;
  assign ph_adv   = (ph_inc >= {1'b0, period}) ? '0 : ph_inc[CNT_W-1:0];
  assign rem_rel  = (ph == '0) ? burst : rem_r[scan_idx_r];
  assign better   = task_en && (rem_rel != '0) && (!found_r || (period < best_per_r));

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    time_nxt     = time_r;
    restart_nxt  = restart_r;
    found_nxt    = found_r;
    best_per_nxt = best_per_r;
    best_rem_nxt = best_rem_r;
    pick_nxt     = pick_r;
    phase_nxt    = phase_r;
    rem_nxt      = rem_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
          restart_nxt  = restart;
          found_nxt    = 1'b0;
          if (restart) begin
            time_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        // Release, pick and phase advance for one task per cycle.
        phase_nxt[scan_idx_r] = task_en ? ph_adv : '0;
        rem_nxt[scan_idx_r]   = task_en ? rem_rel : '0;
        if (better) begin
          found_nxt    = 1'b1;
          best_per_nxt = period;
          best_rem_nxt = rem_rel;
          pick_nxt     = scan_idx_r;
        end
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
          time_nxt  = time_r + 1'b1;
          if (found_r) begin
            rem_nxt[pick_r] = best_rem_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      time_r    <= '0;
      restart_r <= 1'b0;
      found_r   <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        phase_r[i] <= '0;
        rem_r[i]   <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      time_r    <= time_nxt;
      restart_r <= restart_nxt;
      found_r   <= found_nxt;
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    best_per_r <= best_per_nxt;
    best_rem_r <= best_rem_nxt;
    pick_r     <= pick_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res.busy  = found_r;
  assign res.idx   = found_r ? pick_ext[1:0] : 2'd0;
  assign res.done  = found_r && (best_rem_r == CNT_W'(1));
  assign res.tick  = time_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE))
    else $error("tick started while the sequencer was busy");

  a_fin_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_ready) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after handing off a result");

  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_ready) |=> (time_r == $past(time_r) + 32'd1))
    else $error("tick time did not advance by one");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.done) |-> res.busy)
    else $error("burst completion flagged on an idle tick");

endmodule

`default_nettype wire

// ===== sv/rate_monotonic_tick_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                        Contents
// in_       slave      in_tvalid/in_tready/in_tdata    one tick word
// out_      master     out_tvalid/out_tready/out_tdata one schedule result per tick
// cfg_      write      cfg_we/cfg_addr/cfg_wdata       task period and burst registers
//
// Each tick runs from accept to the next accept through an idle state that
// takes the word, a scan of each task in turn through the shared scan unit,
// and a commit state that commits the pick. Reset is synchronous and active
// low; it clears the task registers, time and all per-task counters. A
// stalled output holds the sequencer in its commit cycle, while a result
// already sitting in the output register does not stop the next scan.
module rate_monotonic_tick_scheduler #(
  parameter int NUM_TASKS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input word.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // bit 0: restart; bits 7..1: zero
  input  wire logic [rmts_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result word.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // bit 0: busy_res; bits 2..1: task_index; bit 3: burst_done;
  // bits 35..4: tick_time; bits 39..36: zero
  output logic      [rmts_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Register writes.
  input  wire logic                              cfg_we,
  input  wire logic [rmts_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [rmts_pkg::SET_W-1:0]        cfg_wdata
);
  import rmts_pkg::*;

  logic                  core_idle;
  logic                  start;
  logic [CFG_ADDR_W-1:0] rd_idx;
  logic [SET_W-1:0]      rd_setting;
  logic                  res_valid;
  logic                  res_ready;
  rmts_res_t             res;
  logic                  out_valid_r, out_valid_nxt;
  rmts_res_t             out_res_r, out_res_nxt;

  // A word is taken only while the sequencer is waiting for a tick.
  assign in_tready = core_idle;
  assign start     = in_tvalid && in_tready;

  // The output register can load whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  rmts_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .rd_idx     (rd_idx),
    .rd_setting (rd_setting)
  );

  rmts_core #(
    .NUM_TASKS (NUM_TASKS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .restart    (in_tdata[0]),
    .idle       (core_idle),
    .rd_idx     (rd_idx),
    .rd_setting (rd_setting),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.tick, out_res_r.done, out_res_r.idx, out_res_r.busy};

endmodule

`default_nettype wire
